@@ rtl/core/gice_pkg.sv @@
package gice_pkg;

    // field widths
    localparam int BUTTON_W  = 39;
    localparam int ANGLE_W   = 16;
    localparam int AXIS_W    = 16;
    localparam int THR_W     = 16;
    localparam int HELD_W    = 17;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 1;

    // control map
    localparam int NUM_BUTTONS  = 39;
    localparam int NUM_HAT      = 4;
    localparam int NUM_AXES     = 3;
    localparam int NUM_CONTROLS = 46;

    localparam logic [IDX_W-1:0] HAT_BASE     = 6'd39;
    localparam logic [IDX_W-1:0] AXIS_BASE    = 6'd43;
    localparam logic [IDX_W-1:0] LAST_CONTROL = 6'd45;
    localparam logic [IDX_W-1:0] NO_PRESS     = 6'd46;

    // hat directions in hundredths of degrees
    localparam logic [ANGLE_W-1:0] HAT_UP    = 16'd0;
    localparam logic [ANGLE_W-1:0] HAT_RIGHT = 16'd9000;
    localparam logic [ANGLE_W-1:0] HAT_DOWN  = 16'd18000;
    localparam logic [ANGLE_W-1:0] HAT_LEFT  = 16'd27000;

    // reset values
    localparam logic [THR_W-1:0]         ROTARY_THR_RESET = 16'd800;
    localparam logic [THR_W-1:0]         SLIDER_THR_RESET = 16'd500;
    localparam logic signed [HELD_W-1:0] HELD_RESET       = -17'sd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTARY_THR = 1'b0,
        CFG_SLIDER_THR = 1'b1
    } cfg_index_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_SCAN = 2'd2
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic evaluate;
        logic step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any_event;
        logic hit;
        logic last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/gamepad_input_change_events.sv @@
// Gamepad change detector: each accepted poll (39 buttons, hat angle, two rotary
// axes and a slider) is compared with the state held from earlier polls and
// produces one transaction per change on the m_ channel, in control order:
// buttons 0-38, hat up/right/down/left as controls 39-42, then the axes as
// 43-45 (press when an axis moves beyond its threshold, release on the next
// quiet poll). Each transaction carries the most recently pressed control
// (46 = none) and flags the final event of its poll. A poll is accepted, then
// evaluated, and then scanned one control per cycle up to the last control
// that has an event, holding on a control with an event while the event
// channel stalls; a poll with no changes returns to idle after evaluation. A
// new poll is accepted once the previous poll's last event sits in the output
// register. Thresholds (index 0 rotary, index 1 slider) may only be written
// while no poll is in progress.
module gamepad_input_change_events (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [gice_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gice_pkg::THR_W-1:0]          cfg_wdata,
    // poll channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gice_pkg::BUTTON_W-1:0]       s_button_bits,
    input  logic [gice_pkg::ANGLE_W-1:0]        s_hat_angle,
    input  logic [gice_pkg::AXIS_W-1:0]         s_rotary_small,
    input  logic [gice_pkg::AXIS_W-1:0]         s_rotary_big,
    input  logic [gice_pkg::AXIS_W-1:0]         s_slider,
    // event channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gice_pkg::IDX_W-1:0]          m_control_index,
    output logic                                m_pressed,
    output logic [gice_pkg::IDX_W-1:0]          m_last_pressed,
    output logic                                m_last_in_run
);

    gice_pkg::cmd_t  cmd;
    gice_pkg::stat_t stat;

    // sequencer
    gice_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // compare, state and output datapath
    gice_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_button_bits   (s_button_bits),
        .s_hat_angle     (s_hat_angle),
        .s_rotary_small  (s_rotary_small),
        .s_rotary_big    (s_rotary_big),
        .s_slider        (s_slider),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_control_index (m_control_index),
        .m_pressed       (m_pressed),
        .m_last_pressed  (m_last_pressed),
        .m_last_in_run   (m_last_in_run),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

@@ rtl/core/gice_ctrl.sv @@
module gice_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gice_pkg::stat_t   stat,
    output gice_pkg::cmd_t    cmd
);

    gice_pkg::state_t state_reg;
    gice_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gice_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.evaluate = 1'b0;
        cmd.step     = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            gice_pkg::ST_IDLE: begin
                // no poll is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = gice_pkg::ST_EVAL;
                end
            end
            gice_pkg::ST_EVAL: begin
                cmd.evaluate = 1'b1;
                state_next   = stat.any_event ? gice_pkg::ST_SCAN : gice_pkg::ST_IDLE;
            end
            gice_pkg::ST_SCAN: begin
                if (stat.hit) begin
                    if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.step = 1'b1;
                        if (stat.last) begin
                            state_next = gice_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = gice_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/gice_dp.sv @@
module gice_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [gice_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gice_pkg::THR_W-1:0]          cfg_wdata,
    // poll payload
    input  logic [gice_pkg::BUTTON_W-1:0]       s_button_bits,
    input  logic [gice_pkg::ANGLE_W-1:0]        s_hat_angle,
    input  logic [gice_pkg::AXIS_W-1:0]         s_rotary_small,
    input  logic [gice_pkg::AXIS_W-1:0]         s_rotary_big,
    input  logic [gice_pkg::AXIS_W-1:0]         s_slider,
    // event channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gice_pkg::IDX_W-1:0]          m_control_index,
    output logic                                m_pressed,
    output logic [gice_pkg::IDX_W-1:0]          m_last_pressed,
    output logic                                m_last_in_run,
    // controller link
    input  gice_pkg::cmd_t                      cmd,
    output gice_pkg::stat_t                     stat
);

    localparam int NC = gice_pkg::NUM_CONTROLS;

    // configuration registers
    logic [gice_pkg::THR_W-1:0] rotary_thr_reg;
    logic [gice_pkg::THR_W-1:0] slider_thr_reg;

    // captured poll
    logic [gice_pkg::BUTTON_W-1:0] cap_buttons_reg;
    logic [gice_pkg::ANGLE_W-1:0]  cap_hat_reg;
    logic [gice_pkg::AXIS_W-1:0]   cap_axis_reg [gice_pkg::NUM_AXES];

    // tracked controller state
    logic [gice_pkg::BUTTON_W-1:0]        button_state_reg;
    logic signed [gice_pkg::HELD_W-1:0]   hat_last_reg;
    logic signed [gice_pkg::HELD_W-1:0]   axis_last_reg [gice_pkg::NUM_AXES];
    logic [gice_pkg::NUM_AXES-1:0]        axis_active_reg;
    logic [gice_pkg::IDX_W-1:0]           last_press_reg;

    // scan state
    logic [NC-1:0]              remaining_reg;
    logic [NC-1:0]              press_vec_reg;
    logic [gice_pkg::IDX_W-1:0] idx_reg;

    // output register
    logic                       m_valid_reg;
    logic [gice_pkg::IDX_W-1:0] m_control_reg;
    logic                       m_pressed_reg;
    logic [gice_pkg::IDX_W-1:0] m_last_pressed_reg;
    logic                       m_last_in_run_reg;

    // evaluation results
    logic [NC-1:0]                 event_vec;
    logic [NC-1:0]                 press_vec;
    logic                          hat_changed;
    logic [gice_pkg::NUM_HAT-1:0]  hat_dir;
    logic [gice_pkg::NUM_AXES-1:0] axis_moved;
    logic [NC-1:0]                 rem_after;
    logic                          cur_press;

    // reading more than thr away from the held value, exact signed compare
    function automatic logic moved_beyond(
        input logic signed [gice_pkg::HELD_W-1:0] held,
        input logic [gice_pkg::AXIS_W-1:0]        reading,
        input logic [gice_pkg::THR_W-1:0]         thr
    );
        logic signed [gice_pkg::HELD_W+1:0] h;
        logic signed [gice_pkg::HELD_W+1:0] hi;
        logic signed [gice_pkg::HELD_W+1:0] lo;
        h  = {{2{held[gice_pkg::HELD_W-1]}}, held};
        hi = $signed({3'b000, reading}) + $signed({3'b000, thr});
        lo = $signed({3'b000, reading}) - $signed({3'b000, thr});
        return (h > hi) || (h < lo);
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotary_thr_reg <= gice_pkg::ROTARY_THR_RESET;
            slider_thr_reg <= gice_pkg::SLIDER_THR_RESET;
        end else if (cfg_we) begin
            unique case (gice_pkg::cfg_index_t'(cfg_index))
                gice_pkg::CFG_ROTARY_THR: rotary_thr_reg <= cfg_wdata;
                gice_pkg::CFG_SLIDER_THR: slider_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // poll capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cap_buttons_reg <= s_button_bits;
            cap_hat_reg     <= s_hat_angle;
            cap_axis_reg[0] <= s_rotary_small;
            cap_axis_reg[1] <= s_rotary_big;
            cap_axis_reg[2] <= s_slider;
        end
    end

    // hat decode and axis deadband checks
    always_comb begin
        hat_changed = hat_last_reg != $signed({1'b0, cap_hat_reg});
        hat_dir[0]  = cap_hat_reg == gice_pkg::HAT_UP;
        hat_dir[1]  = cap_hat_reg == gice_pkg::HAT_RIGHT;
        hat_dir[2]  = cap_hat_reg == gice_pkg::HAT_DOWN;
        hat_dir[3]  = cap_hat_reg == gice_pkg::HAT_LEFT;
        axis_moved[0] = moved_beyond(axis_last_reg[0], cap_axis_reg[0], rotary_thr_reg);
        axis_moved[1] = moved_beyond(axis_last_reg[1], cap_axis_reg[1], rotary_thr_reg);
        axis_moved[2] = moved_beyond(axis_last_reg[2], cap_axis_reg[2], slider_thr_reg);
    end

    // per-control event and press vectors
    for (genvar i = 0; i < gice_pkg::BUTTON_W; i++) begin : g_btn
        if (i < gice_pkg::NUM_BUTTONS) begin : g_used
            assign event_vec[i] = cap_buttons_reg[i] ^ button_state_reg[i];
            assign press_vec[i] = cap_buttons_reg[i];
        end else begin : g_unused
            assign event_vec[i] = 1'b0;
            assign press_vec[i] = 1'b0;
        end
    end
    for (genvar j = 0; j < gice_pkg::NUM_HAT; j++) begin : g_hat
        assign event_vec[int'(gice_pkg::HAT_BASE) + j] = hat_changed;
        assign press_vec[int'(gice_pkg::HAT_BASE) + j] = hat_dir[j];
    end
    for (genvar k = 0; k < gice_pkg::NUM_AXES; k++) begin : g_axis
        assign event_vec[int'(gice_pkg::AXIS_BASE) + k] = axis_moved[k] | axis_active_reg[k];
        assign press_vec[int'(gice_pkg::AXIS_BASE) + k] = axis_moved[k];
    end

    // state update on evaluation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_state_reg <= '0;
            hat_last_reg     <= gice_pkg::HELD_RESET;
            for (int k = 0; k < gice_pkg::NUM_AXES; k++) begin
                axis_last_reg[k] <= gice_pkg::HELD_RESET;
            end
            axis_active_reg  <= '0;
        end else if (cmd.evaluate) begin
            button_state_reg <= cap_buttons_reg;
            hat_last_reg     <= $signed({1'b0, cap_hat_reg});
            for (int k = 0; k < gice_pkg::NUM_AXES; k++) begin
                if (axis_moved[k]) begin
                    axis_last_reg[k] <= $signed({1'b0, cap_axis_reg[k]});
                end
            end
            axis_active_reg  <= axis_moved;
        end
    end

    // scan position and pending events
    assign rem_after = remaining_reg & ~({{(NC-1){1'b0}}, 1'b1} << idx_reg);
    assign cur_press = press_vec_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            idx_reg       <= '0;
        end else if (cmd.evaluate) begin
            remaining_reg <= event_vec;
            idx_reg       <= '0;
        end else if (cmd.step) begin
            remaining_reg <= rem_after;
            idx_reg       <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.evaluate) begin
            press_vec_reg <= press_vec;
        end
    end

    // last pressed control tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_press_reg <= gice_pkg::NO_PRESS;
        end else if (cmd.emit && cur_press) begin
            last_press_reg <= idx_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_control_reg      <= idx_reg;
            m_pressed_reg      <= cur_press;
            m_last_pressed_reg <= cur_press ? idx_reg : last_press_reg;
            m_last_in_run_reg  <= rem_after == '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_control_index = m_control_reg;
    assign m_pressed       = m_pressed_reg;
    assign m_last_pressed  = m_last_pressed_reg;
    assign m_last_in_run   = m_last_in_run_reg;

    // status to controller
    assign stat.any_event = |event_vec;
    assign stat.hit       = remaining_reg[idx_reg];
    assign stat.last      = rem_after == '0;
    assign stat.out_free  = !m_valid_reg || m_ready;

`ifndef SYNTH
    // the run's final transaction leaves nothing pending
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && stat.last) |=> (remaining_reg == '0))
        else $error("events still pending after final transaction");

    // pending events never lie past the last control
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (remaining_reg != '0) |-> (idx_reg <= gice_pkg::LAST_CONTROL))
        else $error("scan index beyond last control with events pending");

    // a press transaction reports itself as the last pressed control
    a_press_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_pressed_reg) |-> (m_last_pressed_reg == m_control_reg))
        else $error("press transaction with stale last pressed control");

    // no new transaction overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.emit)
        else $error("output register overwritten while stalled");

    // tracked last press stays a valid code
    a_last_range: assert property (@(posedge aclk) disable iff (!aresetn)
        last_press_reg <= gice_pkg::NO_PRESS)
        else $error("last pressed control out of range");
`endif

endmodule

@@ verif/gamepad_input_change_events_test.sv @@
module gamepad_input_change_events_test;

    // one controller poll as driven on the s_ channel
    typedef struct packed {
        logic [gice_pkg::BUTTON_W-1:0] buttons;
        logic [gice_pkg::ANGLE_W-1:0]  hat;
        logic [gice_pkg::AXIS_W-1:0]   small_axis;
        logic [gice_pkg::AXIS_W-1:0]   big_axis;
        logic [gice_pkg::AXIS_W-1:0]   slider;
    } poll_t;

    // one change event as seen on the m_ channel
    typedef struct packed {
        logic [gice_pkg::IDX_W-1:0] control_index;
        logic                       pressed;
        logic [gice_pkg::IDX_W-1:0] last_pressed;
        logic                       last_in_run;
    } change_t;

    // tracks controller state and the change events still owed by the block
    class change_event_tracker;
        logic [gice_pkg::NUM_BUTTONS-1:0] buttons;
        int                               hat_held;
        int                               axis_held[gice_pkg::NUM_AXES];
        bit                               axis_moving[gice_pkg::NUM_AXES];
        logic [gice_pkg::IDX_W-1:0]       last_press;
        int                               rotary_thr;
        int                               slider_thr;
        change_t                          owed_events[$];
        int                               errors;

        function new();
            buttons    = '0;
            hat_held   = -2;
            last_press = gice_pkg::NO_PRESS;
            rotary_thr = int'(gice_pkg::ROTARY_THR_RESET);
            slider_thr = int'(gice_pkg::SLIDER_THR_RESET);
            errors     = 0;
            for (int k = 0; k < gice_pkg::NUM_AXES; k++) begin
                axis_held[k]   = -2;
                axis_moving[k] = 1'b0;
            end
        endfunction

        function void set_thresholds(logic [gice_pkg::THR_W-1:0] rot,
                                     logic [gice_pkg::THR_W-1:0] sl);
            rotary_thr = int'(rot);
            slider_thr = int'(sl);
        endfunction

        function int outstanding();
            return owed_events.size();
        endfunction

        function void push_event(logic [gice_pkg::IDX_W-1:0] control, bit press);
            change_t e;
            if (press)
                last_press = control;
            e.control_index = control;
            e.pressed       = press;
            e.last_pressed  = last_press;
            e.last_in_run   = 1'b0;
            owed_events.insert(owed_events.size(), e);
        endfunction

        // press on movement past the deadband, release on the next quiet poll
        function void step_axis(int k, logic [gice_pkg::AXIS_W-1:0] reading, int thr);
            int r;
            r = int'(reading);
            if (axis_held[k] > r + thr || axis_held[k] < r - thr) begin
                axis_held[k]   = r;
                axis_moving[k] = 1'b1;
                push_event(gice_pkg::IDX_W'(int'(gice_pkg::AXIS_BASE) + k), 1'b1);
            end else if (axis_moving[k]) begin
                axis_moving[k] = 1'b0;
                push_event(gice_pkg::IDX_W'(int'(gice_pkg::AXIS_BASE) + k), 1'b0);
            end
        endfunction

        // work out the events of one accepted poll
        function void apply_poll(poll_t p);
            int first;
            int dir;
            first = owed_events.size();
            for (int i = 0; i < gice_pkg::NUM_BUTTONS; i++) begin
                if (p.buttons[i] != buttons[i]) begin
                    buttons[i] = p.buttons[i];
                    push_event(gice_pkg::IDX_W'(i), p.buttons[i]);
                end
            end
            if (int'(p.hat) != hat_held) begin
                hat_held = int'(p.hat);
                if (p.hat == gice_pkg::HAT_UP)
                    dir = 0;
                else if (p.hat == gice_pkg::HAT_RIGHT)
                    dir = 1;
                else if (p.hat == gice_pkg::HAT_DOWN)
                    dir = 2;
                else if (p.hat == gice_pkg::HAT_LEFT)
                    dir = 3;
                else
                    dir = -1;
                for (int i = 0; i < gice_pkg::NUM_HAT; i++)
                    push_event(gice_pkg::IDX_W'(int'(gice_pkg::HAT_BASE) + i), i == dir);
            end
            step_axis(0, p.small_axis, rotary_thr);
            step_axis(1, p.big_axis, rotary_thr);
            step_axis(2, p.slider, slider_thr);
            if (owed_events.size() > first)
                owed_events[owed_events.size() - 1].last_in_run = 1'b1;
        endfunction

        function void compare_event(change_t got);
            change_t want;
            if (owed_events.size() == 0) begin
                $error("unexpected event: control_index %0d pressed %0d",
                       got.control_index, got.pressed);
                errors++;
                return;
            end
            want = owed_events.pop_front();
            if (got.control_index !== want.control_index) begin
                $error("control_index: expected %0d, actual %0d",
                       want.control_index, got.control_index);
                errors++;
            end
            if (got.pressed !== want.pressed) begin
                $error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
                errors++;
            end
            if (got.last_pressed !== want.last_pressed) begin
                $error("last_pressed: expected %0d, actual %0d",
                       want.last_pressed, got.last_pressed);
                errors++;
            end
            if (got.last_in_run !== want.last_in_run) begin
                $error("last_in_run: expected %0d, actual %0d",
                       want.last_in_run, got.last_in_run);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn        = 1'b0;
    logic                          cfg_we         = 1'b0;
    gice_pkg::cfg_index_t          cfg_index      = gice_pkg::CFG_ROTARY_THR;
    logic [gice_pkg::THR_W-1:0]    cfg_wdata      = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [gice_pkg::BUTTON_W-1:0] s_button_bits  = '0;
    logic [gice_pkg::ANGLE_W-1:0]  s_hat_angle    = '0;
    logic [gice_pkg::AXIS_W-1:0]   s_rotary_small = '0;
    logic [gice_pkg::AXIS_W-1:0]   s_rotary_big   = '0;
    logic [gice_pkg::AXIS_W-1:0]   s_slider       = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [gice_pkg::IDX_W-1:0]    m_control_index;
    logic                          m_pressed;
    logic [gice_pkg::IDX_W-1:0]    m_last_pressed;
    logic                          m_last_in_run;

    change_event_tracker tracker = new();
    poll_t               last_poll = '0;
    int                  sender_idle_pct = 0;
    int                  sink_stall_pct  = 0;

    gamepad_input_change_events dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button_bits   (s_button_bits),
        .s_hat_angle     (s_hat_angle),
        .s_rotary_small  (s_rotary_small),
        .s_rotary_big    (s_rotary_big),
        .s_slider        (s_slider),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_control_index (m_control_index),
        .m_pressed       (m_pressed),
        .m_last_pressed  (m_last_pressed),
        .m_last_in_run   (m_last_in_run)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // event sink with random stalls
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // check every accepted event transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.compare_event({m_control_index, m_pressed, m_last_pressed, m_last_in_run});
    end

    function automatic poll_t mk_poll(logic [gice_pkg::BUTTON_W-1:0] b,
                                      logic [gice_pkg::ANGLE_W-1:0] h,
                                      logic [gice_pkg::AXIS_W-1:0] a0,
                                      logic [gice_pkg::AXIS_W-1:0] a1,
                                      logic [gice_pkg::AXIS_W-1:0] a2);
        poll_t p;
        p.buttons    = b;
        p.hat        = h;
        p.small_axis = a0;
        p.big_axis   = a1;
        p.slider     = a2;
        return p;
    endfunction

    // axis reading near the previous one, near the deadband edge, or anywhere
    function automatic logic [gice_pkg::AXIS_W-1:0] jitter(
        logic [gice_pkg::AXIS_W-1:0] prev, int thr);
        int r;
        int d;
        int v;
        r = $urandom_range(0, 19);
        if (r < 12)
            d = $urandom_range(0, thr / 2);
        else if (r < 17)
            d = thr - 1 + int'($urandom_range(0, 2));
        else
            return gice_pkg::AXIS_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 1))
            v = int'(prev) + d;
        else
            v = int'(prev) - d;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[gice_pkg::AXIS_W-1:0];
    endfunction

    // mostly small changes from the last poll so that quiet polls and releases happen
    function automatic poll_t random_poll();
        poll_t p;
        int    r;
        p = last_poll;
        r = $urandom_range(0, 19);
        if (r < 3)
            p.buttons = gice_pkg::BUTTON_W'({$urandom, $urandom});
        else if (r < 17)
            repeat ($urandom_range(0, 2))
                p.buttons[$urandom_range(0, gice_pkg::NUM_BUTTONS - 1)] ^= 1'b1;
        r = $urandom_range(0, 19);
        if (r < 3)
            p.hat = gice_pkg::ANGLE_W'($urandom_range(0, 65535));
        else if (r < 8)
            case ($urandom_range(0, 3))
                0: p.hat = gice_pkg::HAT_UP;
                1: p.hat = gice_pkg::HAT_RIGHT;
                2: p.hat = gice_pkg::HAT_DOWN;
                default: p.hat = gice_pkg::HAT_LEFT;
            endcase
        p.small_axis = jitter(p.small_axis, tracker.rotary_thr);
        p.big_axis   = jitter(p.big_axis, tracker.rotary_thr);
        p.slider     = jitter(p.slider, tracker.slider_thr);
        return p;
    endfunction

    task automatic send_poll(poll_t p);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_valid        <= 1'b1;
        s_button_bits  <= p.buttons;
        s_hat_angle    <= p.hat;
        s_rotary_small <= p.small_axis;
        s_rotary_big   <= p.big_axis;
        s_slider       <= p.slider;
        do @(posedge aclk); while (!s_ready);
        tracker.apply_poll(p);
        last_poll = p;
    endtask

    // stop sending, wait for every owed event, then let a quiet poll finish
    task automatic drain(int settle);
        s_valid <= 1'b0;
        while (tracker.outstanding() > 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_thresholds(logic [gice_pkg::THR_W-1:0] rot,
                                    logic [gice_pkg::THR_W-1:0] sl);
        cfg_we    <= 1'b1;
        cfg_index <= gice_pkg::CFG_ROTARY_THR;
        cfg_wdata <= rot;
        @(posedge aclk);
        cfg_index <= gice_pkg::CFG_SLIDER_THR;
        cfg_wdata <= sl;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.set_thresholds(rot, sl);
    endtask

    initial begin
        int idle_of[4];
        int stall_of[4];
        logic [gice_pkg::THR_W-1:0] rot_of[4];
        logic [gice_pkg::THR_W-1:0] sl_of[4];
        idle_of  = '{0, 76, 0, 32};
        stall_of = '{0, 0, 76, 32};
        rot_of   = '{gice_pkg::ROTARY_THR_RESET, 16'd0, 16'hFFFF, 16'd0};
        sl_of    = '{gice_pkg::SLIDER_THR_RESET, 16'hFFFF, 16'd0, 16'd0};
        rot_of[3] = gice_pkg::THR_W'($urandom_range(1, 3000));
        sl_of[3]  = gice_pkg::THR_W'($urandom_range(1, 3000));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset thresholds, first poll, full sweeps, deadband edges
        send_poll(mk_poll('0, gice_pkg::HAT_UP, 16'd0, 16'd0, 16'd0));
        send_poll(mk_poll('1, gice_pkg::HAT_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_poll(mk_poll('1, gice_pkg::HAT_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_poll(mk_poll('1, gice_pkg::HAT_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_poll(mk_poll('0, gice_pkg::HAT_DOWN, 16'd0, 16'd0, 16'd0));
        send_poll(mk_poll(39'h55_5555_5555, gice_pkg::HAT_LEFT, 16'd801, 16'd801, 16'd501));
        // hat to centered, then centered to another centered value
        send_poll(mk_poll(39'h2A_AAAA_AAAA, 16'hFFFF, 16'd801, 16'd801, 16'd501));
        send_poll(mk_poll(39'h2A_AAAA_AAAA, 16'd1, 16'd1601, 16'd1601, 16'd1001));
        send_poll(mk_poll(39'h2A_AAAA_AAAA, gice_pkg::HAT_RIGHT,
                          16'd1602, 16'd1602, 16'd1002));
        send_poll(mk_poll(39'h40_0000_0001, gice_pkg::HAT_RIGHT,
                          16'd1602, 16'd1602, 16'd1002));
        drain(4);
        write_thresholds(16'd0, 16'd0);
        send_poll(mk_poll(39'h40_0000_0001, gice_pkg::HAT_RIGHT,
                          16'd1602, 16'd1602, 16'd1002));
        send_poll(mk_poll(39'h40_0000_0001, gice_pkg::HAT_RIGHT,
                          16'd1603, 16'd1601, 16'd1002));
        send_poll(mk_poll('0, 16'd9001, 16'd1603, 16'd0, 16'd0));
        drain(4);
        write_thresholds(16'hFFFF, 16'hFFFE);
        send_poll(mk_poll('0, 16'd9001, 16'd1603, 16'hFFFF, 16'hFFFF));
        send_poll(mk_poll('0, 16'd9001, 16'd1603, 16'hFFFF, 16'hFFFF));

        // random phases, each with its own idling mix and thresholds
        for (int ph = 0; ph < 4; ph++) begin
            drain(4);
            write_thresholds(rot_of[ph], sl_of[ph]);
            sender_idle_pct = idle_of[ph];
            sink_stall_pct  = stall_of[ph];
            for (int n = 0; n < 91; n++) begin
                if (n == 45)
                    drain(0);
                send_poll(random_poll());
            end
        end

        drain(60);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
